@@ src/roz_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers for the affine source address generator.
// No dependencies; every other file in src uses this package.
package roz_pkg;

    // largest screen coordinate plus one that counts as on screen
    localparam int SCREEN_DIM = 1024;

    // bits of the position sum that the result needs (integer bits 11:0 at 8 fraction bits)
    localparam int POS_W   = 20;
    localparam int COORD_W = 10;
    localparam int STEP_W  = 13;
    localparam int SRC_W   = 12;

    // fixed offset of the start point in columns and rows
    localparam int X_OFFSET = 36;
    localparam int Y_OFFSET = 3;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_ATTR    = 3'd0,
        REG_XX      = 3'd1,
        REG_XY      = 3'd2,
        REG_YX      = 3'd3,
        REG_YY      = 3'd4,
        REG_START_X = 3'd5,
        REG_START_Y = 3'd6
    } reg_idx_t;

    localparam logic [15:0] ATTR_RESET = 16'h8000;

    // one request: a screen pixel
    typedef struct packed {
        logic [COORD_W-1:0] screen_x;
        logic [COORD_W-1:0] screen_y;
    } pix_t;

    // one result: source position and layer attributes
    typedef struct packed {
        logic [SRC_W-1:0] source_x;
        logic [SRC_W-1:0] source_y;
        logic [SRC_W-1:0] palette_base;
        logic [3:0]       layer_priority;
        logic             layer_enabled;
    } res_t;

    // decoded layer controls, shared by all stages
    typedef struct packed {
        logic signed [STEP_W-1:0] inc_xx;
        logic signed [STEP_W-1:0] inc_xy;
        logic signed [STEP_W-1:0] inc_yx;
        logic signed [STEP_W-1:0] inc_yy;
        logic [15:0]              start_x;
        logic [15:0]              start_y;
        logic [1:0]               size_code;
        logic [2:0]               left_base;
        logic [2:0]               top_base;
        logic [3:0]               prio;
        logic [3:0]               bank;
        logic                     disable_n;
    } layer_cfg_t;

    // stage 1 payload: the four step products
    typedef struct packed {
        logic [POS_W-1:0] x_col;
        logic [POS_W-1:0] x_row;
        logic [POS_W-1:0] y_col;
        logic [POS_W-1:0] y_row;
        logic             on_screen;
    } prod_t;

    // stage 2 payload: integer source position before masking
    typedef struct packed {
        logic [SRC_W-1:0] pos_x;
        logic [SRC_W-1:0] pos_y;
        logic             on_screen;
    } pos_t;

    // 13-bit signed step: bit15 is the sign, bits11-0 the low bits
    function automatic logic signed [STEP_W-1:0] step13(input logic [15:0] w);
        return {w[15], w[11:0]};
    endfunction

    // coordinate times signed step, wrapped to the position width
    function automatic logic [POS_W-1:0] mul_step(input logic [COORD_W-1:0] v,
                                                  input logic signed [STEP_W-1:0] s);
        logic signed [COORD_W+STEP_W:0] p;
        p = $signed({1'b0, v}) * s;
        return p[POS_W-1:0];
    endfunction

    // start point of one axis: start<<4 + 36*col + 3*row, wrapped
    function automatic logic [POS_W-1:0] axis_start(input logic [15:0] start,
                                                    input logic signed [STEP_W-1:0] col,
                                                    input logic signed [STEP_W-1:0] row);
        logic [POS_W-1:0] col_w;
        logic [POS_W-1:0] row_w;
        col_w = POS_W'(col);
        row_w = POS_W'(row);
        return {start, 4'b0000} + (col_w << 5) + (col_w << 2) + (row_w << 1) + row_w;
    endfunction

endpackage

@@ src/roz_mul.sv @@
`timescale 1ns / 1ps
// Stage 1: registers the four coordinate-by-step products and the on-screen flag.
// Depends on roz_pkg.
module roz_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  roz_pkg::pix_t       pix,
    input  roz_pkg::layer_cfg_t cfg,
    output logic                dn_valid,
    input  logic                dn_ready,
    output roz_pkg::prod_t      dn_data
);

    logic           valid_reg;
    logic           valid_next;
    roz_pkg::prod_t data_reg;
    roz_pkg::prod_t data_next;

    // take a new request when empty or when the next stage drains us
    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        valid_next = up_ready ? up_valid : valid_reg;
        data_next.x_col = roz_pkg::mul_step(pix.screen_x, cfg.inc_xx);
        data_next.x_row = roz_pkg::mul_step(pix.screen_y, cfg.inc_yx);
        data_next.y_col = roz_pkg::mul_step(pix.screen_x, cfg.inc_xy);
        data_next.y_row = roz_pkg::mul_step(pix.screen_y, cfg.inc_yy);
        data_next.on_screen = (32'(pix.screen_x) < roz_pkg::SCREEN_DIM)
                           && (32'(pix.screen_y) < roz_pkg::SCREEN_DIM);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // hold the payload while stalled
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

@@ src/roz_sum.sv @@
`timescale 1ns / 1ps
// Stage 2: adds start point and products, keeps the integer position bits.
// Depends on roz_pkg.
module roz_sum (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  roz_pkg::prod_t      up_data,
    input  roz_pkg::layer_cfg_t cfg,
    output logic                dn_valid,
    input  logic                dn_ready,
    output roz_pkg::pos_t       dn_data
);

    logic                      valid_reg;
    logic                      valid_next;
    roz_pkg::pos_t             data_reg;
    roz_pkg::pos_t             data_next;
    logic [roz_pkg::POS_W-1:0] sum_x;
    logic [roz_pkg::POS_W-1:0] sum_y;

    assign up_ready = !valid_reg || dn_ready;

    // sum each axis; integer part sits above 8 fraction bits
    always_comb
    begin
        sum_x = roz_pkg::axis_start(cfg.start_x, cfg.inc_xx, cfg.inc_yx)
              + up_data.x_col + up_data.x_row;
        sum_y = roz_pkg::axis_start(cfg.start_y, cfg.inc_xy, cfg.inc_yy)
              + up_data.y_col + up_data.y_row;
        valid_next          = up_ready ? up_valid : valid_reg;
        data_next.pos_x     = sum_x[roz_pkg::POS_W-1:8];
        data_next.pos_y     = sum_y[roz_pkg::POS_W-1:8];
        data_next.on_screen = up_data.on_screen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

@@ src/roz_out.sv @@
`timescale 1ns / 1ps
// Stage 3: masks to plane size, adds the bases and registers the result.
// Depends on roz_pkg.
module roz_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  roz_pkg::pos_t       up_data,
    input  roz_pkg::layer_cfg_t cfg,
    output logic                res_valid,
    input  logic                res_stall,
    output roz_pkg::res_t       res
);

    logic                      valid_reg;
    logic                      valid_next;
    roz_pkg::res_t             data_reg;
    roz_pkg::res_t             data_next;
    logic [roz_pkg::SRC_W-1:0] plane_mask;

    assign up_ready = !valid_reg || !res_stall;

    always_comb
    begin
        // plane size 512 << code, minus one
        case (cfg.size_code)
            2'd0:    plane_mask = 12'h1ff;
            2'd1:    plane_mask = 12'h3ff;
            2'd2:    plane_mask = 12'h7ff;
            default: plane_mask = 12'hfff;
        endcase
        valid_next = up_ready ? up_valid : valid_reg;
        data_next.source_x       = (up_data.pos_x & plane_mask) + {cfg.left_base, 9'd0};
        data_next.source_y       = (up_data.pos_y & plane_mask) + {cfg.top_base, 9'd0};
        data_next.palette_base   = {cfg.bank, 8'd0};
        data_next.layer_priority = cfg.prio;
        data_next.layer_enabled  = cfg.disable_n && up_data.on_screen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign res_valid = valid_reg;
    assign res       = data_reg;

endmodule

@@ src/roz_affine_source_address.sv @@
`timescale 1ns / 1ps
// Affine source address generator, top level: control registers and a 3-stage pipeline.
// Pipeline: 3 register stages. Throughput 1 request per cycle; input stalls only when all
// stages are full and the result is stalled. Stages: step multipliers, position adder,
// mask/base add.
// Reset (rst_n low, async) empties the pipeline and sets attr to 0x8000, other words to 0.
// Depends on roz_pkg, roz_mul, roz_sum, roz_out.
module roz_affine_source_address (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  roz_pkg::pix_t req_data,
    output logic          res_valid,
    input  logic          res_stall,
    output roz_pkg::res_t res_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_data
);

    logic [15:0]         attr_reg;
    logic [15:0]         xx_reg;
    logic [15:0]         xy_reg;
    logic [15:0]         yx_reg;
    logic [15:0]         yy_reg;
    logic [15:0]         start_x_reg;
    logic [15:0]         start_y_reg;
    roz_pkg::layer_cfg_t cfg;

    logic           s1_ready;
    logic           s1_valid;
    roz_pkg::prod_t s1_data;
    logic           s2_ready;
    logic           s2_valid;
    roz_pkg::pos_t  s2_data;
    logic           s3_ready;

    assign cfg_ready = 1'b1;

    // write control registers; indexes past the last are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg    <= roz_pkg::ATTR_RESET;
            xx_reg      <= '0;
            xy_reg      <= '0;
            yx_reg      <= '0;
            yy_reg      <= '0;
            start_x_reg <= '0;
            start_y_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                roz_pkg::REG_ATTR:    attr_reg    <= cfg_data;
                roz_pkg::REG_XX:      xx_reg      <= cfg_data;
                roz_pkg::REG_XY:      xy_reg      <= cfg_data;
                roz_pkg::REG_YX:      yx_reg      <= cfg_data;
                roz_pkg::REG_YY:      yy_reg      <= cfg_data;
                roz_pkg::REG_START_X: start_x_reg <= cfg_data;
                roz_pkg::REG_START_Y: start_y_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // decode the control words
    always_comb
    begin
        cfg.inc_xx    = roz_pkg::step13(xx_reg);
        cfg.inc_xy    = roz_pkg::step13(xy_reg);
        cfg.inc_yx    = roz_pkg::step13(yx_reg);
        cfg.inc_yy    = roz_pkg::step13(yy_reg);
        cfg.start_x   = start_x_reg;
        cfg.start_y   = start_y_reg;
        cfg.size_code = attr_reg[9:8];
        cfg.left_base = xx_reg[14:12];
        cfg.top_base  = xy_reg[14:12];
        cfg.prio      = attr_reg[7:4];
        cfg.bank      = attr_reg[3:0];
        cfg.disable_n = !attr_reg[15];
    end

    assign req_stall = !s1_ready;

    roz_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (req_valid),
        .up_ready (s1_ready),
        .pix      (req_data),
        .cfg      (cfg),
        .dn_valid (s1_valid),
        .dn_ready (s2_ready),
        .dn_data  (s1_data)
    );

    roz_sum u_sum (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ready (s2_ready),
        .up_data  (s1_data),
        .cfg      (cfg),
        .dn_valid (s2_valid),
        .dn_ready (s3_ready),
        .dn_data  (s2_data)
    );

    roz_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (s2_valid),
        .up_ready  (s3_ready),
        .up_data   (s2_data),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res_data)
    );

endmodule

@@ src/roz_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for roz_affine_source_address, attached by bind.
// Depends on roz_pkg and the top level's ports.
module roz_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          res_valid,
    input logic          res_stall,
    input roz_pkg::res_t res_data,
    input logic          cfg_ready
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("stalled result changed");

    // back-pressure only when the result is valid and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> res_valid && res_stall)
        else $error("request stalled with room in the pipeline");

    // an accepted request shows up at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |-> ##3 res_valid)
        else $error("result missing three cycles after request");

    // control writes are never refused
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("control port not ready");

endmodule

bind roz_affine_source_address roz_checker u_roz_checker (.*);

@@ dv/tb_roz_affine_source_address.sv @@
`timescale 1ns / 1ps
// Self-checking bench for roz_affine_source_address: table-driven directed writes and requests,
// then random register settings and requests with random stalls on both sides.
// Depends on roz_pkg and the block's RTL in src.
module tb_roz_affine_source_address;

    // register index outside the map; writes to it must be dropped
    localparam logic [2:0] REG_NONE = 3'd7;
    localparam int TIMEOUT_NS = 2_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 150;
    localparam logic [15:0] EDGE_WORDS [4] = '{16'h0000, 16'hffff, 16'h8000, 16'h7fff};

    // one row of the directed table: a register write or a pixel request
    typedef struct packed {
        logic          is_cfg;
        logic [2:0]    reg_sel;
        logic [15:0]   val;
        roz_pkg::pix_t px;
        logic          typed;
        roz_pkg::res_t want;
    } dir_row_t;

    localparam int DIR_N = 25;
    localparam roz_pkg::res_t RES_ZERO = '{12'h000, 12'h000, 12'h000, 4'h0, 1'b0};

    logic clk;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    roz_pkg::pix_t req_data = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    roz_pkg::res_t res_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // shadow copy of the layer control words
    logic [15:0] layer_regs [7];
    roz_pkg::res_t source_q [$];
    int mismatches = 0;
    bit calm = 1'b0;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    dir_row_t dir_rows [DIR_N] = '{
        '{1'b0, roz_pkg::REG_ATTR, 16'h0000, '{10'd0, 10'd0}, 1'b1, RES_ZERO},
        '{1'b0, roz_pkg::REG_ATTR, 16'h0000, '{10'd1023, 10'd1023}, 1'b1, RES_ZERO},
        '{1'b0, roz_pkg::REG_ATTR, 16'h0000, '{10'd1023, 10'd0}, 1'b0, RES_ZERO},
        '{1'b1, roz_pkg::REG_ATTR, 16'h0000, '{10'd0, 10'd0}, 1'b0, RES_ZERO},
        '{1'b0, roz_pkg::REG_ATTR, 16'h0000, '{10'd0, 10'd0}, 1'b1,
          '{12'h000, 12'h000, 12'h000, 4'h0, 1'b1}},
        '{1'b1, roz_pkg::REG_ATTR, 16'h7fff, '{10'd0, 10'd0}, 1'b0, RES_ZERO},
        '{1'b0, roz_pkg::REG_ATTR, 16'h0000, '{10'd1023, 10'd1023}, 1'b1,
          '{12'h000, 12'h000, 12'hf00, 4'hf, 1'b1}},
        '{1'b1, roz_pkg::REG_XX, 16'h7000, '{10'd0, 10'd0}, 1'b0, RES_ZERO},
        '{1'b1, roz_pkg::REG_XY, 16'h7000, '{10'd0, 10'd0}, 1'b0, RES_ZERO},
        '{1'b0, roz_pkg::REG_ATTR, 16'h0000, '{10'd512, 10'd777}, 1'b1,
          '{12'he00, 12'he00, 12'hf00, 4'hf, 1'b1}},
        '{1'b1, roz_pkg::REG_XX, 16'h8000, '{10'd0, 10'd0}, 1'b0, RES_ZERO},
        '{1'b1, roz_pkg::REG_XY, 16'h0fff, '{10'd0, 10'd0}, 1'b0, RES_ZERO},
        '{1'b1, roz_pkg::REG_YX, 16'hffff, '{10'd0, 10'd0}, 1'b0, RES_ZERO},
        '{1'b1, roz_pkg::REG_YY, 16'h7fff, '{10'd0, 10'd0}, 1'b0, RES_ZERO},
        '{1'b1, roz_pkg::REG_START_X, 16'h8000, '{10'd0, 10'd0}, 1'b0, RES_ZERO},
        '{1'b1, roz_pkg::REG_START_Y, 16'h7fff, '{10'd0, 10'd0}, 1'b0, RES_ZERO},
        '{1'b1, REG_NONE, 16'hffff, '{10'd0, 10'd0}, 1'b0, RES_ZERO},
        '{1'b0, roz_pkg::REG_ATTR, 16'h0000, '{10'd0, 10'd0}, 1'b0, RES_ZERO},
        '{1'b0, roz_pkg::REG_ATTR, 16'h0000, '{10'd1023, 10'd1023}, 1'b0, RES_ZERO},
        '{1'b0, roz_pkg::REG_ATTR, 16'h0000, '{10'd1023, 10'd0}, 1'b0, RES_ZERO},
        '{1'b0, roz_pkg::REG_ATTR, 16'h0000, '{10'd0, 10'd1023}, 1'b0, RES_ZERO},
        '{1'b1, roz_pkg::REG_ATTR, 16'h8100, '{10'd0, 10'd0}, 1'b0, RES_ZERO},
        '{1'b0, roz_pkg::REG_ATTR, 16'h0000, '{10'd341, 10'd682}, 1'b0, RES_ZERO},
        '{1'b1, roz_pkg::REG_ATTR, 16'h0200, '{10'd0, 10'd0}, 1'b0, RES_ZERO},
        '{1'b0, roz_pkg::REG_ATTR, 16'h0000, '{10'd682, 10'd341}, 1'b0, RES_ZERO}
    };

    roz_affine_source_address u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    // one axis: start + x*col + y*row in 16.16, masked to plane size, plus base
    function automatic logic [11:0] axis_source(input logic [15:0] start,
                                                input logic [31:0] col,
                                                input logic [31:0] row,
                                                input logic [9:0] x,
                                                input logic [9:0] y,
                                                input logic [31:0] mask,
                                                input logic [31:0] base);
        logic [31:0] s;
        logic [31:0] c;
        s = ({{16{start[15]}}, start} << 4) + 32'(roz_pkg::X_OFFSET) * col
          + 32'(roz_pkg::Y_OFFSET) * row;
        c = (s << 8) + {22'd0, x} * (col << 8) + {22'd0, y} * (row << 8);
        return 12'(((c >> 16) & mask) + base);
    endfunction

    // source position and layer attributes for one pixel under the current words
    function automatic roz_pkg::res_t predict_source(input roz_pkg::pix_t p);
        logic [15:0] attr;
        logic [31:0] mask;
        roz_pkg::res_t r;
        attr = layer_regs[roz_pkg::REG_ATTR];
        mask = (32'd512 << attr[9:8]) - 32'd1;
        r.source_x = axis_source(layer_regs[roz_pkg::REG_START_X],
                                 {{20{layer_regs[roz_pkg::REG_XX][15]}},
                                  layer_regs[roz_pkg::REG_XX][11:0]},
                                 {{20{layer_regs[roz_pkg::REG_YX][15]}},
                                  layer_regs[roz_pkg::REG_YX][11:0]},
                                 p.screen_x, p.screen_y, mask,
                                 {20'd0, layer_regs[roz_pkg::REG_XX][14:12], 9'd0});
        r.source_y = axis_source(layer_regs[roz_pkg::REG_START_Y],
                                 {{20{layer_regs[roz_pkg::REG_XY][15]}},
                                  layer_regs[roz_pkg::REG_XY][11:0]},
                                 {{20{layer_regs[roz_pkg::REG_YY][15]}},
                                  layer_regs[roz_pkg::REG_YY][11:0]},
                                 p.screen_x, p.screen_y, mask,
                                 {20'd0, layer_regs[roz_pkg::REG_XY][14:12], 9'd0});
        r.palette_base = {attr[3:0], 8'd0};
        r.layer_priority = attr[7:4];
        r.layer_enabled = !attr[15] && (p.screen_x < roz_pkg::SCREEN_DIM)
                       && (p.screen_y < roz_pkg::SCREEN_DIM);
        return r;
    endfunction

    // offer one request, with random gaps ahead of it, and log its expected result
    task automatic send_pixel(input roz_pkg::pix_t p, input logic typed,
                              input roz_pkg::res_t want);
        while (!calm && $urandom_range(0, 99) < 16)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= p;
        do @(posedge clk); while (req_stall);
        source_q.push_back(typed ? want : predict_source(p));
    endtask

    // write one control word once every outstanding result has come back
    task automatic write_reg(input logic [2:0] sel, input logic [15:0] val);
        req_valid <= 1'b0;
        while (source_q.size() != 0) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (sel <= roz_pkg::REG_START_Y)
            layer_regs[sel] = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // check results against the oldest expectation; drive random and long stalls
    always @(posedge clk)
    begin
        roz_pkg::res_t want;
        if (res_valid && !res_stall)
        begin
            if (source_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: result expected none got %h", $time, res_data);
            end
            else
            begin
                want = source_q.pop_front();
                if (res_data !== want)
                begin
                    mismatches++;
                    if (res_data.source_x !== want.source_x)
                        $display("%0t: source_x expected %0d got %0d", $time,
                                 want.source_x, res_data.source_x);
                    if (res_data.source_y !== want.source_y)
                        $display("%0t: source_y expected %0d got %0d", $time,
                                 want.source_y, res_data.source_y);
                    if (res_data.palette_base !== want.palette_base)
                        $display("%0t: palette_base expected %0d got %0d", $time,
                                 want.palette_base, res_data.palette_base);
                    if (res_data.layer_priority !== want.layer_priority)
                        $display("%0t: layer_priority expected %0d got %0d", $time,
                                 want.layer_priority, res_data.layer_priority);
                    if (res_data.layer_enabled !== want.layer_enabled)
                        $display("%0t: layer_enabled expected %0d got %0d", $time,
                                 want.layer_enabled, res_data.layer_enabled);
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else if (hold_go && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            res_stall <= 1'b1;
        end
        else if (calm)
            res_stall <= 1'b0;
        else
            res_stall <= ($urandom_range(0, 99) < 16);
    end

    initial
    begin
        roz_pkg::pix_t px;
        logic [15:0] val;
        dir_row_t row;
        layer_regs[roz_pkg::REG_ATTR] = roz_pkg::ATTR_RESET;
        for (int r = 1; r < 7; r++)
            layer_regs[3'(r)] = 16'h0000;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        for (int i = 0; i < DIR_N; i++)
        begin
            row = dir_rows[5'(i)];
            if (row.is_cfg)
                write_reg(row.reg_sel, row.val);
            else
                send_pixel(row.px, row.typed, row.want);
        end

        // random phases: new control words, then a run of random requests
        for (int ph = 0; ph < PHASES; ph++)
        begin
            for (int r = 0; r < 7; r++)
            begin
                if (ph == 2)
                    val = 16'h7fff;
                else if (ph == 3)
                    val = 16'h8000;
                else if ($urandom_range(0, 3) == 0)
                    val = EDGE_WORDS[2'($urandom_range(0, 3))];
                else
                    val = 16'($urandom);
                // keep the layer enabled most of the time
                if (r == roz_pkg::REG_ATTR && ph > 3 && $urandom_range(0, 3) != 0)
                    val[15] = 1'b0;
                write_reg(3'(r), val);
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_NONE, 16'($urandom));
            hold_go = (ph >= 1);
            calm = (ph == 5);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                px.screen_x = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1) * 1023)
                                                          : 10'($urandom_range(0, 1023));
                px.screen_y = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1) * 1023)
                                                          : 10'($urandom_range(0, 1023));
                send_pixel(px, 1'b0, RES_ZERO);
            end
        end
        calm = 1'b0;

        // drain the pipeline, then report success or failure
        req_valid <= 1'b0;
        while (source_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
src/roz_pkg.sv
src/roz_mul.sv
src/roz_sum.sv
src/roz_out.sv
src/roz_affine_source_address.sv
src/roz_checker.sv
dv/tb_roz_affine_source_address.sv
